>>> design/hfe_pkg.sv
// shared constants, types and helpers for the huffman byte encoder
// no dependencies; used by hfe_code_table and huffman_byte_encoder
package hfe_pkg;

    localparam int SYMBOL_BITS      = 8;
    localparam int TABLE_DEPTH      = 1 << SYMBOL_BITS;
    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int CODE_FIELD_BITS  = 32;
    localparam int LEN_W            = 6;
    localparam int PACK_BITS        = 8;
    localparam int REQ_W            = 2;
    localparam int S_TDATA_W        = 48;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_FINISH = 2'd2
    } hfe_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MERGE,
        ST_EMIT,
        ST_FLUSH,
        ST_TRAIL
    } hfe_state_t;

    // control group from the sequencer to the code table
    typedef struct packed {
        logic                   wr_en;
        logic                   rd_en;
        logic [SYMBOL_BITS-1:0] addr;
    } hfe_tbl_ctrl_t;

    // usable code length: bounded by both the parameter and the load field
    function automatic int code_limit(input int max_len);
        code_limit = (max_len > CODE_FIELD_BITS) ? CODE_FIELD_BITS : max_len;
    endfunction

endpackage

>>> design/hfe_code_table.sv
// code table memory: one {length, code} entry per symbol, registered read
// depends on hfe_pkg; instantiated by huffman_byte_encoder
module hfe_code_table #(
    parameter int MAX_CODE_LEN = hfe_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                                           clk,
    input  hfe_pkg::hfe_tbl_ctrl_t                         ctrl,
    input  logic [hfe_pkg::LEN_W-1:0]                      wr_len,
    input  logic [hfe_pkg::CODE_FIELD_BITS-1:0]            wr_bits,
    output logic [hfe_pkg::LEN_W-1:0]                      rd_len,
    output logic [hfe_pkg::code_limit(MAX_CODE_LEN)-1:0]   rd_code
);

    localparam int LIMIT   = hfe_pkg::code_limit(MAX_CODE_LEN);
    localparam int ENTRY_W = hfe_pkg::LEN_W + LIMIT;

    logic [ENTRY_W-1:0]        mem [hfe_pkg::TABLE_DEPTH];
    logic [ENTRY_W-1:0]        rd_data_reg;
    logic [hfe_pkg::LEN_W-1:0] len_sat;
    logic [LIMIT-1:0]          code_mask;

    // over-long codes saturate to the limit, bits above the length are dropped
    always_comb
    begin
        if (wr_len > hfe_pkg::LEN_W'(LIMIT))
        begin
            len_sat = hfe_pkg::LEN_W'(LIMIT);
        end
        else
        begin
            len_sat = wr_len;
        end
        code_mask = ~({LIMIT{1'b1}} << len_sat);
    end

    // write and read never hit the same cycle: the sequencer issues one request at a time
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.addr] <= {len_sat, wr_bits[LIMIT-1:0] & code_mask};
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[ctrl.addr];
        end
    end

    assign rd_len  = rd_data_reg[ENTRY_W-1 -: hfe_pkg::LEN_W];
    assign rd_code = rd_data_reg[LIMIT-1:0];

endmodule

>>> design/huffman_byte_encoder.sv
// huffman byte encoder top level: request sequencer, bit packer, output register
// depends on hfe_pkg and hfe_code_table
//
// usage
//   slave channel s_*: one request per handshake. s_tuser carries the request
//   kind (load table entry, encode symbol, finish stream). load writes one
//   code table entry; encode appends the symbol's code msb first to the
//   pending bits; finish sends the partial byte if any, then a trailer byte
//   holding the count of valid bits in it (0 to 7), and clears the packer.
//   master channel m_*: one packed byte per handshake, m_tlast on the final
//   byte produced by a request.
//   timing: one request at a time. load writes its table entry when accepted.
//   encode reads the table, then merges into the packer, then emits each
//   completed byte. finish sends the partial byte, if any, then the trailer.
//   the table memory's single read port and the byte-wide output register set these steps.
//   an output register parts the two sides: the next request is taken while
//   the last byte of the previous one still waits.
//   reset clears the packer and the handshake state; table entries hold garbage until loaded.
//   when the receiver stalls, byte emission pauses and s_tready stays low
//   until the request's bytes have all reached the output register.
module huffman_byte_encoder #(
    parameter int MAX_CODE_LEN = hfe_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // symbol[7:0], code_bits[39:8], code_len[45:40], zero pad[47:46]
    input  logic [hfe_pkg::S_TDATA_W-1:0]       s_tdata,
    // req_type[1:0]
    input  logic [hfe_pkg::REQ_W-1:0]           s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_byte[7:0]
    output logic [hfe_pkg::PACK_BITS-1:0]       m_tdata,
    output logic                                m_tlast
);

    localparam int LIMIT = hfe_pkg::code_limit(MAX_CODE_LEN);
    localparam int ACC_W = LIMIT + hfe_pkg::PACK_BITS - 1;
    localparam int CNT_W = $clog2(ACC_W + 1);

    hfe_pkg::hfe_state_t            state_reg, state_next;
    logic [ACC_W-1:0]               acc_reg, acc_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [hfe_pkg::PACK_BITS-1:0]  m_tdata_reg, m_tdata_next;
    logic                           m_tlast_reg, m_tlast_next;

    hfe_pkg::hfe_tbl_ctrl_t         tbl_ctrl;
    logic [hfe_pkg::LEN_W-1:0]      rd_len;
    logic [LIMIT-1:0]               rd_code;

    logic                           accept;
    logic                           out_free;
    logic [CNT_W-1:0]               merge_cnt;
    logic [CNT_W-1:0]               merge_sh;
    logic [CNT_W-1:0]               emit_rem;

    hfe_code_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_table (
        .clk     (clk),
        .ctrl    (tbl_ctrl),
        .wr_len  (s_tdata[45:40]),
        .wr_bits (s_tdata[39:8]),
        .rd_len  (rd_len),
        .rd_code (rd_code)
    );

    assign s_tready = (state_reg == hfe_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // pending bits sit left-aligned in acc_reg; new code lands right below them
    assign merge_cnt = cnt_reg + CNT_W'(rd_len);
    assign merge_sh  = CNT_W'(ACC_W) - merge_cnt;
    assign emit_rem  = cnt_reg - CNT_W'(hfe_pkg::PACK_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= hfe_pkg::ST_IDLE;
            acc_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        tbl_ctrl.wr_en = 1'b0;
        tbl_ctrl.rd_en = 1'b0;
        tbl_ctrl.addr  = s_tdata[hfe_pkg::SYMBOL_BITS-1:0];

        case (state_reg)
            hfe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        hfe_pkg::REQ_LOAD:
                        begin
                            tbl_ctrl.wr_en = 1'b1;
                        end
                        hfe_pkg::REQ_ENCODE:
                        begin
                            tbl_ctrl.rd_en = 1'b1;
                            state_next     = hfe_pkg::ST_MERGE;
                        end
                        hfe_pkg::REQ_FINISH:
                        begin
                            if (cnt_reg != '0)
                            begin
                                state_next = hfe_pkg::ST_FLUSH;
                            end
                            else
                            begin
                                state_next = hfe_pkg::ST_TRAIL;
                            end
                        end
                        default:
                        begin
                            state_next = hfe_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            hfe_pkg::ST_MERGE:
            begin
                acc_next = acc_reg | (ACC_W'(rd_code) << merge_sh);
                cnt_next = merge_cnt;
                if (merge_cnt >= CNT_W'(hfe_pkg::PACK_BITS))
                begin
                    state_next = hfe_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = hfe_pkg::ST_IDLE;
                end
            end
            hfe_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = acc_reg[ACC_W-1 -: hfe_pkg::PACK_BITS];
                    m_tlast_next  = (emit_rem < CNT_W'(hfe_pkg::PACK_BITS));
                    acc_next      = acc_reg << hfe_pkg::PACK_BITS;
                    cnt_next      = emit_rem;
                    if (emit_rem < CNT_W'(hfe_pkg::PACK_BITS))
                    begin
                        state_next = hfe_pkg::ST_IDLE;
                    end
                end
            end
            hfe_pkg::ST_FLUSH:
            begin
                // partial byte, count kept for the trailer
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = acc_reg[ACC_W-1 -: hfe_pkg::PACK_BITS];
                    m_tlast_next  = 1'b0;
                    state_next    = hfe_pkg::ST_TRAIL;
                end
            end
            hfe_pkg::ST_TRAIL:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(hfe_pkg::PACK_BITS - 3){1'b0}}, cnt_reg[2:0]};
                    m_tlast_next  = 1'b1;
                    acc_next      = '0;
                    cnt_next      = '0;
                    state_next    = hfe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hfe_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTH
    // between requests fewer than a byte of bits may be pending
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hfe_pkg::ST_IDLE |-> cnt_reg < CNT_W'(hfe_pkg::PACK_BITS))
        else $error("packer holds a full byte while idle");

    // emission only runs with a whole byte available
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hfe_pkg::ST_EMIT |-> cnt_reg >= CNT_W'(hfe_pkg::PACK_BITS))
        else $error("byte emitted with too few bits");

    // the trailer clears the packer
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == hfe_pkg::ST_TRAIL && out_free |=> cnt_reg == '0 && acc_reg == '0)
        else $error("packer not cleared after trailer");

    // the table is read only on an accepted encode request
    assert property (@(posedge clk) disable iff (!rst_n)
        tbl_ctrl.rd_en |=> state_reg == hfe_pkg::ST_MERGE)
        else $error("table read without merge");
`endif

endmodule

>>> bench/tb_huffman_byte_encoder.sv
// testbench for huffman_byte_encoder: directed table, then random load/encode/finish/unused requests
// checks every output byte and tlast against typed directed bytes or a local bit-packing predictor; needs hfe_pkg
`timescale 1ns / 100ps

module tb_huffman_byte_encoder;

    localparam int          CODE_LEN_MAX = hfe_pkg::MAX_CODE_LEN_DEF;
    localparam int          LEN_LIMIT    = (CODE_LEN_MAX < hfe_pkg::CODE_FIELD_BITS) ?
                                           CODE_LEN_MAX : hfe_pkg::CODE_FIELD_BITS;
    localparam int          NUM_DIR      = 25;
    localparam int          NUM_RANDOM   = 450;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 20;
    localparam logic [hfe_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam logic [2:0]  USE_MODEL    = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } enc_byte_t;

    // n_typed = USE_MODEL means the row is checked against the predictor,
    // otherwise typed holds n_typed bytes, first one in [31:24]
    typedef struct packed {
        logic [hfe_pkg::REQ_W-1:0] req;
        logic [7:0]                sym;
        logic [31:0]               bits;
        logic [5:0]                len;
        logic [2:0]                n_typed;
        logic [31:0]               typed;
    } dir_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [hfe_pkg::S_TDATA_W-1:0]   s_tdata = '0;
    logic [hfe_pkg::REQ_W-1:0]       s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [hfe_pkg::PACK_BITS-1:0]   m_tdata;
    logic                            m_tlast;

    // predictor state
    logic [5:0]             tbl_len  [hfe_pkg::TABLE_DEPTH];
    logic [31:0]            tbl_code [hfe_pkg::TABLE_DEPTH];
    bit                     tbl_loaded [hfe_pkg::TABLE_DEPTH];
    logic [7:0]             loaded_syms [$];
    logic [7:0]             pend_byte;
    int                     pend_cnt;

    enc_byte_t              expected_bytes [$];
    enc_byte_t              predicted_bytes [$];
    dir_row_t               dir_rows [NUM_DIR];

    int                     cycle_count = 0;
    int                     mismatches = 0;
    int                     bytes_checked = 0;
    int                     n_loads = 0;
    int                     n_encodes = 0;
    int                     n_finishes = 0;
    int                     n_unused = 0;
    int                     burst_left = 0;
    int                     hold_left = 0;

    huffman_byte_encoder #(
        .MAX_CODE_LEN (CODE_LEN_MAX)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes still expected",
                     cycle_count, expected_bytes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver stalls: mostly short, a few long, some long stall-free stretches
    always @(posedge clk)
    begin
        int r;
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 5)
            begin
                m_tready  <= 1'b1;
                hold_left <= $urandom_range(50, 150);
            end
            else if (r < 60)
            begin
                m_tready  <= 1'b1;
                hold_left <= $urandom_range(0, 20);
            end
            else if (r < 93)
            begin
                m_tready  <= 1'b0;
                hold_left <= $urandom_range(0, 3);
            end
            else
            begin
                m_tready  <= 1'b0;
                hold_left <= $urandom_range(10, 40);
            end
        end
    end

    // output checker
    always @(posedge clk)
    begin
        enc_byte_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_bytes.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected byte %02h last %0b at cycle %0d",
                             m_tdata, m_tlast, cycle_count);
                mismatches++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                bytes_checked++;
                if (m_tdata !== want.data || m_tlast !== want.last)
                begin
                    if (mismatches < 10)
                        $display("byte %0d: expected %02h last %0b, got %02h last %0b",
                                 bytes_checked, want.data, want.last, m_tdata, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            burst_left = $urandom_range(20, 40);
            return 0;
        end
        else if (r < 47)
            return 0;
        else if (r < 87)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(15, 40);
    endfunction

    // computes the bytes a request produces and updates the local packer state
    task automatic predict_packed_bytes(input logic [hfe_pkg::REQ_W-1:0] req,
                                        input logic [7:0] sym,
                                        input logic [31:0] bits, input logic [5:0] len);
        int        eff_len;
        int        i;
        bit        have_prev;
        logic [7:0] prev;
        have_prev = 0;
        prev = '0;
        case (req)
            hfe_pkg::REQ_LOAD:
            begin
                eff_len = (len > LEN_LIMIT) ? LEN_LIMIT : len;
                if (eff_len < 32)
                    bits = bits & ((32'd1 << eff_len) - 32'd1);
                tbl_len[sym]  = eff_len[5:0];
                tbl_code[sym] = bits;
                if (!tbl_loaded[sym])
                    loaded_syms.insert(loaded_syms.size(), sym);
                tbl_loaded[sym] = 1'b1;
                n_loads++;
            end
            hfe_pkg::REQ_ENCODE:
            begin
                for (i = tbl_len[sym]; i > 0; i--)
                begin
                    pend_byte[7 - pend_cnt] = tbl_code[sym][i - 1];
                    pend_cnt++;
                    if (pend_cnt == hfe_pkg::PACK_BITS)
                    begin
                        // hold back one byte so the final one can carry last
                        if (have_prev)
                            predicted_bytes.insert(predicted_bytes.size(), {prev, 1'b0});
                        prev      = pend_byte;
                        have_prev = 1;
                        pend_byte = '0;
                        pend_cnt  = 0;
                    end
                end
                if (have_prev)
                    predicted_bytes.insert(predicted_bytes.size(), {prev, 1'b1});
                n_encodes++;
            end
            hfe_pkg::REQ_FINISH:
            begin
                if (pend_cnt != 0)
                    predicted_bytes.insert(predicted_bytes.size(), {pend_byte, 1'b0});
                predicted_bytes.insert(predicted_bytes.size(), {8'(pend_cnt), 1'b1});
                pend_byte = '0;
                pend_cnt  = 0;
                n_finishes++;
            end
            default:
                n_unused++;
        endcase
    endtask

    // drives one request, waits for its handshake, then queues what it should produce
    task automatic issue_request(input logic [hfe_pkg::REQ_W-1:0] req, input logic [7:0] sym,
                                 input logic [31:0] bits, input logic [5:0] len,
                                 input logic [2:0] n_typed, input logic [31:0] typed);
        int gap;
        int k;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {2'b00, len, bits, sym};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_packed_bytes(req, sym, bits, len);
        if (n_typed == USE_MODEL)
        begin
            for (k = 0; k < predicted_bytes.size(); k++)
                expected_bytes.insert(expected_bytes.size(), predicted_bytes[k]);
        end
        else
        begin
            for (k = 0; k < n_typed; k++)
                expected_bytes.insert(expected_bytes.size(),
                                      {typed[31 - 8*k -: 8], k == n_typed - 1});
        end
        predicted_bytes.delete();
    endtask

    initial
    begin
        int         n;
        int         r;
        dir_row_t   row;
        logic [5:0] len;
        logic [7:0] sym;

        // directed part: extremes, every request kind, saturation, zero length, empty finish
        dir_rows[0]  = {hfe_pkg::REQ_FINISH, 8'h00, 32'h0000_0000, 6'd0,  3'd1, 32'h0000_0000};
        dir_rows[1]  = {hfe_pkg::REQ_LOAD,   8'h00, 32'hFFFF_FFA5, 6'd8,  3'd0, 32'h0000_0000};
        dir_rows[2]  = {hfe_pkg::REQ_ENCODE, 8'h00, 32'hDEAD_BEEF, 6'd63, 3'd1, 32'hA500_0000};
        dir_rows[3]  = {hfe_pkg::REQ_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32, 3'd0, 32'h0000_0000};
        dir_rows[4]  = {hfe_pkg::REQ_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  3'd4, 32'hFFFF_FFFF};
        dir_rows[5]  = {hfe_pkg::REQ_LOAD,   8'h01, 32'hFFFF_FFFF, 6'd0,  3'd0, 32'h0000_0000};
        dir_rows[6]  = {hfe_pkg::REQ_ENCODE, 8'h01, 32'hFFFF_FFFF, 6'd63, 3'd0, 32'h0000_0000};
        dir_rows[7]  = {hfe_pkg::REQ_LOAD,   8'h02, 32'h1234_5678, 6'd63, 3'd0, 32'h0000_0000};
        dir_rows[8]  = {hfe_pkg::REQ_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  3'd4, 32'h1234_5678};
        dir_rows[9]  = {REQ_UNUSED,          8'hAA, 32'h5555_5555, 6'd42, 3'd0, 32'h0000_0000};
        dir_rows[10] = {hfe_pkg::REQ_LOAD,   8'h03, 32'hFFFF_FFFD, 6'd3,  3'd0, 32'h0000_0000};
        dir_rows[11] = {hfe_pkg::REQ_ENCODE, 8'h03, 32'h0000_0000, 6'd0,  3'd0, 32'h0000_0000};
        dir_rows[12] = {hfe_pkg::REQ_FINISH, 8'hFF, 32'hFFFF_FFFF, 6'd63, 3'd2, 32'hA003_0000};
        dir_rows[13] = {hfe_pkg::REQ_LOAD,   8'h05, 32'h0000_007F, 6'd7,  3'd0, 32'h0000_0000};
        dir_rows[14] = {hfe_pkg::REQ_ENCODE, 8'h05, 32'h0000_0000, 6'd0,  3'd0, 32'h0000_0000};
        dir_rows[15] = {hfe_pkg::REQ_FINISH, 8'h00, 32'h0000_0000, 6'd0,  3'd2, 32'hFE07_0000};
        dir_rows[16] = {hfe_pkg::REQ_LOAD,   8'h80, 32'h5555_5555, 6'd33, USE_MODEL, 32'h0};
        dir_rows[17] = {hfe_pkg::REQ_ENCODE, 8'h03, 32'h0000_0000, 6'd0,  USE_MODEL, 32'h0};
        dir_rows[18] = {hfe_pkg::REQ_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  USE_MODEL, 32'h0};
        dir_rows[19] = {hfe_pkg::REQ_LOAD,   8'h40, 32'hAAAA_AAA9, 6'd1,  USE_MODEL, 32'h0};
        dir_rows[20] = {hfe_pkg::REQ_ENCODE, 8'h40, 32'h0000_0000, 6'd0,  USE_MODEL, 32'h0};
        dir_rows[21] = {hfe_pkg::REQ_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  USE_MODEL, 32'h0};
        dir_rows[22] = {hfe_pkg::REQ_FINISH, 8'h00, 32'h0000_0000, 6'd0,  USE_MODEL, 32'h0};
        dir_rows[23] = {hfe_pkg::REQ_FINISH, 8'h00, 32'h0000_0000, 6'd0,  3'd1, 32'h0000_0000};
        dir_rows[24] = {hfe_pkg::REQ_ENCODE, 8'h00, 32'hCAFE_F00D, 6'd21, USE_MODEL, 32'h0};

        pend_byte = '0;
        pend_cnt  = 0;
        for (n = 0; n < hfe_pkg::TABLE_DEPTH; n++)
        begin
            tbl_loaded[n] = 1'b0;
            tbl_len[n]    = '0;
            tbl_code[n]   = '0;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < NUM_DIR; n++)
        begin
            row = dir_rows[n];
            issue_request(row.req, row.sym, row.bits, row.len, row.n_typed, row.typed);
        end

        // random part: mostly encodes of loaded symbols, with reloads, finishes and unused requests mixed in
        for (n = 0; n < NUM_RANDOM; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 22)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    len = 6'd0;
                else if (r < 65)
                    len = 6'($urandom_range(1, 10));
                else if (r < 90)
                    len = 6'($urandom_range(11, 32));
                else
                    len = 6'($urandom_range(33, 63));
                issue_request(hfe_pkg::REQ_LOAD, 8'($urandom_range(0, 255)), $urandom, len,
                              USE_MODEL, 32'h0);
            end
            else if (r < 85)
            begin
                sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
                issue_request(hfe_pkg::REQ_ENCODE, sym, $urandom, 6'($urandom_range(0, 63)),
                              USE_MODEL, 32'h0);
            end
            else if (r < 97)
                issue_request(hfe_pkg::REQ_FINISH, 8'($urandom_range(0, 255)), $urandom,
                              6'($urandom_range(0, 63)), USE_MODEL, 32'h0);
            else
                issue_request(REQ_UNUSED, 8'($urandom_range(0, 255)), $urandom,
                              6'($urandom_range(0, 63)), USE_MODEL, 32'h0);
        end
        s_tvalid <= 1'b0;

        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d loads, %0d encodes, %0d finishes, %0d unused requests",
                 n_loads, n_encodes, n_finishes, n_unused);
        $display("checked %0d output bytes, %0d mismatches", bytes_checked, mismatches);
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
